@@ rtl/tql_pkg.sv @@
// Shared types and constants for the tabular Q-learning agent.
// Used by tql_ctrl, tql_datapath and tabular_q_learning_agent; no dependencies.
package tql_pkg;

   localparam int DEF_GRID_SIDE = 17;
   localparam int NUM_ACTIONS   = 4;
   localparam int ACTION_BITS   = 2;
   localparam int VALUE_BITS    = 16;
   localparam int ROW_BITS      = NUM_ACTIONS * VALUE_BITS;
   localparam int RATE_BITS     = 9;
   localparam int EPS_BITS      = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [1:0] REQ_START    = 2'd0;
   localparam logic [1:0] REQ_CONTINUE = 2'd1;
   localparam logic [1:0] REQ_END      = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_LEARN_RATE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DISCOUNT   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXPLORE    = 2'd2;

   localparam logic [RATE_BITS-1:0] LEARN_RATE_RST = 9'd128;
   localparam logic [RATE_BITS-1:0] DISCOUNT_RST   = 9'd230;
   localparam logic [EPS_BITS-1:0]  EXPLORE_RST    = 16'd0;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [4:0]        cell_x;
      logic [4:0]        cell_y;
      logic signed [15:0] reward;
      logic [15:0]       random_draw;
      logic [1:0]        random_action;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         action;
      logic               was_greedy;
      logic signed [15:0] new_value;
   } rsp_item_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic rd_cell;
      logic rd_prev;
      logic mul1;
      logic sum;
      logic mul2;
      logic wb;
      logic choose;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic do_update;
   } ctrl_stat_type;

endpackage

@@ rtl/tabular_q_learning_agent.sv @@
// Tabular Q-learning agent, epsilon-greedy. Start beats skip the update states that
// continue/end beats pass through; the next start is taken in the strobe cycle, so a new
// beat is not taken while one is in flight, and the rate is set by the single read port
// of the table and the two multiply stages of the update. Results cannot be stalled.
// Synchronous reset restores registers and writes the reset row to every table entry,
// with busy high while it runs. Depends on tql_pkg, tql_ctrl, tql_datapath.
module tabular_q_learning_agent
   import tql_pkg::*;
#(
   parameter int GRID_SIDE = DEF_GRID_SIDE
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_item_type             req_data,
   output logic                     rsp_valid,
   output rsp_item_type             rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   assign csr_ready = 1'b1;

   tql_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   tql_datapath #(
      .GRID_SIDE (GRID_SIDE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/tql_ctrl.sv @@
// Sequencer for the Q-learning agent: table clear, read, update, choose.
// Depends on tql_pkg; drives tql_datapath through ctrl_cmd_type.
module tql_ctrl
   import tql_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_RD_CELL = 4'd2;
   localparam logic [3:0] ST_RD_PREV = 4'd3;
   localparam logic [3:0] ST_MUL1    = 4'd4;
   localparam logic [3:0] ST_SUM     = 4'd5;
   localparam logic [3:0] ST_MUL2    = 4'd6;
   localparam logic [3:0] ST_WB      = 4'd7;
   localparam logic [3:0] ST_CHOOSE  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_RD_CELL;
            end
         end
         ST_RD_CELL: begin
            cmd.rd_cell = 1'b1;
            state_in    = ST_RD_PREV;
         end
         ST_RD_PREV: begin
            cmd.rd_prev = 1'b1;
            state_in    = stat.do_update ? ST_MUL1 : ST_CHOOSE;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_WB;
         end
         ST_WB: begin
            cmd.wb   = 1'b1;
            state_in = ST_CHOOSE;
         end
         ST_CHOOSE: begin
            cmd.choose = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |=> (state_ff != ST_CLEAR))
      else $error("table clear re-entered");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##1 busy ##1 busy)
      else $error("busy dropped early after accept");

   a_mul_needs_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL1) |-> stat.do_update)
      else $error("update path entered without update");

   a_update_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL1) |=> ##2 (state_ff == ST_WB))
      else $error("update pipeline length broken");

endmodule

@@ rtl/tql_datapath.sv @@
// Datapath of the Q-learning agent: value table, update arithmetic, argmax.
// Depends on tql_pkg; sequenced by tql_ctrl.
module tql_datapath
   import tql_pkg::*;
#(
   parameter int GRID_SIDE = DEF_GRID_SIDE
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   output ctrl_stat_type            stat,
   input  req_item_type             req_data,
   input  logic                     csr_valid,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output logic                     rsp_valid,
   output rsp_item_type             rsp_data
);

   localparam int NUM_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int CELL_BITS = $clog2(NUM_CELLS);
   localparam int V         = VALUE_BITS;
   localparam int M_BITS    = V + RATE_BITS + 1;
   localparam int S_BITS    = ((M_BITS > 24) ? M_BITS : 24) + 1;
   localparam int P_BITS    = S_BITS + RATE_BITS + 1;
   localparam int N_BITS    = ((P_BITS > M_BITS + 8) ? P_BITS : M_BITS + 8) + 1;
   localparam int Q_BITS    = N_BITS - 16;
   localparam logic [6:0] MaxCoord = 7'(GRID_SIDE - 1);
   localparam logic signed [Q_BITS-1:0] QMax = Q_BITS'((64'sd1 <<< (V - 1)) - 64'sd1);
   localparam logic signed [Q_BITS-1:0] QMin = Q_BITS'(-(64'sd1 <<< (V - 1)));
   localparam logic [V-1:0] HalfVal = (V > 8) ? V'(128) : V'(127);

   typedef struct packed {
      logic [ACTION_BITS-1:0] act;
      logic signed [V-1:0]    val;
   } best_type;

   function automatic best_type best_of(input logic [ROW_BITS-1:0] row);
      best_type            r;
      logic signed [V-1:0] v;
      r.act = '0;
      r.val = signed'(row[V-1:0]);
      for (int z = 1; z < NUM_ACTIONS; z++) begin
         v = signed'(row[z*V +: V]);
         if (v > r.val) begin
            r.val = v;
            r.act = ACTION_BITS'(z);
         end
      end
      return r;
   endfunction

   function automatic logic [ROW_BITS-1:0] reset_row();
      logic [ROW_BITS-1:0] r;
      r = '0;
      r[V-1:0]   = HalfVal;
      r[2*V-1:V] = HalfVal;
      return r;
   endfunction

   logic [ROW_BITS-1:0] mem [NUM_CELLS];

   logic [RATE_BITS-1:0]   learn_rate_ff;
   logic [RATE_BITS-1:0]   discount_ff;
   logic [EPS_BITS-1:0]    explore_ff;
   req_item_type           item_ff;
   logic [CELL_BITS-1:0]   cell_ff;
   logic [CELL_BITS-1:0]   cell_in;
   logic                   upd_ff;
   logic                   upd_in;
   logic                   chs_ff;
   logic                   chs_in;
   logic [CELL_BITS-1:0]   prev_cell_ff;
   logic [ACTION_BITS-1:0] prev_act_ff;
   logic [CELL_BITS-1:0]   clr_ff;
   logic [ROW_BITS-1:0]    rd_ff;
   logic [ROW_BITS-1:0]    cell_row_ff;
   logic signed [V-1:0]    best_val_ff;
   logic [ROW_BITS-1:0]    prev_row_ff;
   logic signed [M_BITS-1:0] m1_ff;
   logic signed [M_BITS-1:0] m2_ff;
   logic signed [S_BITS-1:0] s_ff;
   logic signed [P_BITS-1:0] p_ff;
   logic signed [V-1:0]    newv_ff;
   logic signed [V-1:0]    newv_in;
   rsp_item_type           rsp_ff;
   rsp_item_type           rsp_in;
   logic                   rsp_valid_ff;

   logic [6:0]             cx_c;
   logic [6:0]             cy_c;
   best_type               rd_best;
   best_type               row_best;
   logic signed [V-1:0]    old_val;
   logic signed [RATE_BITS:0] disc_s;
   logic signed [RATE_BITS:0] lr_s;
   logic signed [RATE_BITS:0] wt_s;
   logic signed [23:0]     rew_s;
   logic signed [N_BITS-1:0] n_val;
   logic signed [Q_BITS-1:0] q_val;
   logic                   we;
   logic [CELL_BITS-1:0]   wr_addr;
   logic [ROW_BITS-1:0]    wr_data;
   logic                   re;
   logic [CELL_BITS-1:0]   rd_addr;
   logic [ACTION_BITS-1:0] choice;
   logic                   greedy;

   always_comb begin
      cx_c    = ({2'b00, req_data.cell_x} > MaxCoord) ? MaxCoord : {2'b00, req_data.cell_x};
      cy_c    = ({2'b00, req_data.cell_y} > MaxCoord) ? MaxCoord : {2'b00, req_data.cell_y};
      cell_in = CELL_BITS'(CELL_BITS'(cx_c) * CELL_BITS'(GRID_SIDE) + CELL_BITS'(cy_c));
      upd_in  = req_data.req_type inside {REQ_CONTINUE, REQ_END};
      chs_in  = req_data.req_type inside {REQ_START, REQ_CONTINUE};
   end

   assign disc_s  = signed'({1'b0, discount_ff});
   assign lr_s    = signed'({1'b0, learn_rate_ff});
   assign wt_s    = (RATE_BITS + 1)'(256) - lr_s;
   assign rew_s   = signed'({item_ff.reward, 8'h00});
   assign rd_best = best_of(rd_ff);
   assign old_val = signed'(rd_ff[prev_act_ff*V +: V]);

   // floor by arithmetic shift, then saturate
   always_comb begin
      n_val = N_BITS'(p_ff) + N_BITS'(signed'({m2_ff, 8'h00}));
      q_val = n_val[N_BITS-1:16];
      if (q_val > QMax) begin
         newv_in = V'(QMax);
      end else if (q_val < QMin) begin
         newv_in = V'(QMin);
      end else begin
         newv_in = q_val[V-1:0];
      end
   end

   always_comb begin
      we      = cmd.clear_wr | cmd.wb;
      wr_addr = cmd.clear_wr ? clr_ff : prev_cell_ff;
      wr_data = prev_row_ff;
      wr_data[prev_act_ff*V +: V] = newv_in;
      if (cmd.clear_wr) wr_data = reset_row();
      re      = cmd.rd_cell | cmd.rd_prev;
      rd_addr = cmd.rd_cell ? cell_ff : prev_cell_ff;
   end

   always_ff @(posedge clock) begin
      if (we) mem[wr_addr] <= wr_data;
      if (re) rd_ff <= mem[rd_addr];
   end

   assign row_best = best_of(cell_row_ff);
   assign greedy   = item_ff.random_draw > explore_ff;
   assign choice   = greedy ? row_best.act : item_ff.random_action;

   always_comb begin
      rsp_in            = '0;
      rsp_in.new_value  = upd_ff ? 16'(newv_ff) : 16'sd0;
      if (chs_ff) begin
         rsp_in.action     = choice;
         rsp_in.was_greedy = greedy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff <= LEARN_RATE_RST;
         discount_ff   <= DISCOUNT_RST;
         explore_ff    <= EXPLORE_RST;
         prev_cell_ff  <= '0;
         prev_act_ff   <= '0;
         clr_ff        <= '0;
         upd_ff        <= 1'b0;
         chs_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_LEARN_RATE: learn_rate_ff <= csr_data[RATE_BITS-1:0];
               CSR_DISCOUNT:   discount_ff   <= csr_data[RATE_BITS-1:0];
               CSR_EXPLORE:    explore_ff    <= csr_data[EPS_BITS-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.clear_wr) clr_ff <= clr_ff + 1'b1;
         if (cmd.accept) begin
            upd_ff <= upd_in;
            chs_ff <= chs_in;
         end
         if (cmd.choose && chs_ff) begin
            prev_cell_ff <= cell_ff;
            prev_act_ff  <= choice;
         end
         rsp_valid_ff <= cmd.choose;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_data;
         cell_ff <= cell_in;
      end
      if (cmd.rd_prev) begin
         cell_row_ff <= rd_ff;
         best_val_ff <= rd_best.val;
      end
      if (cmd.mul1) begin
         prev_row_ff <= rd_ff;
         m1_ff       <= M_BITS'(disc_s) * M_BITS'(best_val_ff);
         m2_ff       <= M_BITS'(old_val) * M_BITS'(wt_s);
      end
      if (cmd.sum) s_ff <= S_BITS'(m1_ff) + S_BITS'(rew_s);
      if (cmd.mul2) p_ff <= P_BITS'(s_ff) * P_BITS'(lr_s);
      if (cmd.wb) begin
         newv_ff <= newv_in;
         if (prev_cell_ff == cell_ff) cell_row_ff[prev_act_ff*V +: V] <= newv_in;
      end
      if (cmd.choose) rsp_ff <= rsp_in;
   end

   assign stat.clear_done = (clr_ff == CELL_BITS'(NUM_CELLS - 1));
   assign stat.do_update  = upd_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule
